@@ sv/b64d_pkg.sv @@
// Package with shared types, codes and the symbol decode table of the base64 decoder.
`timescale 1ns / 1ps
`default_nettype none
package b64d_pkg;

    // Status codes carried in the end result.
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_INVALID    = 2'd1;
    localparam logic [1:0] STATUS_INCOMPLETE = 2'd2;

    // Marker returned by the symbol decoder for a character outside the alphabet.
    localparam logic [7:0] SYM_INVALID = 8'hFF;

    // Characters with a special meaning.
    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Default depth of the command queue between front and back.
    localparam int CMDQ_DEPTH_DEFAULT = 4;

    // One command from the front: the bytes of a finished group and/or the end result.
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  nbytes;
        logic        fin;
        logic [1:0]  status;
    } cmd_t;

    function automatic logic [7:0] symbol_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            v = c - 8'h41;
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            v = c - 8'h61 + 8'd26;
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30 + 8'd52;
        end
        else if (c == CH_PLUS)
        begin
            v = 8'd62;
        end
        else if (c == CH_SLASH)
        begin
            v = 8'd63;
        end
        else if (c == CH_PAD)
        begin
            v = 8'd0;
        end
        else
        begin
            v = SYM_INVALID;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

@@ sv/b64d_front.sv @@
// Front end: accepts characters, gathers groups and issues byte and end commands.
`timescale 1ns / 1ps
`default_nettype none
module b64d_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [7:0]    char_code,
    input  wire logic          end_of_text,
    input  wire logic          empty_marker,
    input  wire logic          cmd_full,
    output b64d_pkg::cmd_t     cmd,
    output logic               cmd_push
);
    import b64d_pkg::*;

    logic [17:0] hold_reg;
    logic [17:0] hold_next;
    logic [1:0]  group_reg;
    logic [1:0]  group_next;
    logic [2:0]  pad_reg;
    logic [2:0]  pad_next;
    logic [1:0]  error_reg;
    logic [1:0]  error_next;

    logic        accept;
    logic        last;
    logic [7:0]  sym;
    logic        group_done;

    assign accept = push && !cmd_full;
    assign last   = end_of_text || empty_marker;
    assign sym    = symbol_value(char_code);

    always_comb
    begin
        hold_next  = hold_reg;
        group_next = group_reg;
        pad_next   = pad_reg;
        error_next = error_reg;
        group_done = 1'b0;
        cmd.word   = {hold_reg, sym[5:0]};
        cmd.nbytes = 2'd0;
        cmd.fin    = 1'b0;
        cmd.status = STATUS_OK;

        if (!empty_marker && error_reg == STATUS_OK)
        begin
            if (sym == SYM_INVALID)
            begin
                error_next = STATUS_INVALID;
            end
            else
            begin
                if (char_code == CH_PAD)
                begin
                    pad_next = pad_reg + 3'd1;
                end
                if (group_reg != 2'd3)
                begin
                    hold_next  = {hold_reg[11:0], sym[5:0]};
                    group_next = group_reg + 2'd1;
                end
                else
                begin
                    group_done = 1'b1;
                end
            end
        end

        if (group_done)
        begin
            // Pads counted so far, this character included, set the byte count.
            if (pad_next == 3'd0)
            begin
                cmd.nbytes = 2'd3;
            end
            else if (pad_next == 3'd1)
            begin
                cmd.nbytes = 2'd2;
            end
            else
            begin
                cmd.nbytes = 2'd1;
            end
            hold_next  = '0;
            group_next = 2'd0;
            pad_next   = 3'd0;
        end

        if (last)
        begin
            cmd.fin = 1'b1;
            if (error_next != STATUS_OK)
            begin
                cmd.status = error_next;
            end
            else if (group_next != 2'd0)
            begin
                cmd.status = STATUS_INCOMPLETE;
            end
            hold_next  = '0;
            group_next = 2'd0;
            pad_next   = 3'd0;
            error_next = STATUS_OK;
        end

        cmd_push = accept && (group_done || last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg  <= '0;
            group_reg <= 2'd0;
            pad_reg   <= 3'd0;
            error_reg <= STATUS_OK;
        end
        else if (accept)
        begin
            hold_reg  <= hold_next;
            group_reg <= group_next;
            pad_reg   <= pad_next;
            error_reg <= error_next;
        end
    end

    // The string state is clear once the last character of a string is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (group_reg == 2'd0 && error_reg == STATUS_OK && pad_reg == 3'd0))
        else $error("front state not cleared after end of string");

    // A command always carries at least one result.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> (cmd.nbytes != 2'd0 || cmd.fin))
        else $error("front issued an empty command");

endmodule
`default_nettype wire

@@ sv/b64d_cmdq.sv @@
// Short command queue between the front end and the result sequencer.
`timescale 1ns / 1ps
`default_nettype none
module b64d_cmdq
#(
    parameter int DEPTH = b64d_pkg::CMDQ_DEPTH_DEFAULT
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire b64d_pkg::cmd_t wr_data,
    input  wire logic           rd_en,
    output b64d_pkg::cmd_t      rd_data,
    output logic                rd_valid,
    output logic                is_full
);
    import b64d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign rd_data  = mem_reg[rd_ptr_reg];
    assign rd_valid = (count_reg != '0);
    assign is_full  = (count_reg == FULL_CNT);

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && is_full))
        else $error("command queue written while full");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && !rd_valid))
        else $error("command queue read while empty");

endmodule
`default_nettype wire

@@ sv/b64d_back.sv @@
// Back end: expands each command into data and end results behind an output register.
`timescale 1ns / 1ps
`default_nettype none
module b64d_back
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire b64d_pkg::cmd_t cmd,
    input  wire logic           cmd_valid,
    output logic                cmd_pop,
    output logic                empty,
    input  wire logic           pop,
    output logic [7:0]          data_byte,
    output logic                has_byte,
    output logic                is_final,
    output logic [1:0]          status
);
    import b64d_pkg::*;

    logic       out_valid_reg;
    logic [7:0] data_reg;
    logic       has_reg;
    logic       fin_reg;
    logic [1:0] status_reg;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;

    logic       out_load;
    logic [2:0] total;
    logic       is_last;
    logic       is_data;
    logic [7:0] sel_byte;

    assign out_load = !out_valid_reg || pop;
    assign total    = {1'b0, cmd.nbytes} + {2'b00, cmd.fin};
    assign is_last  = ({1'b0, idx_reg} == (total - 3'd1));
    assign is_data  = (idx_reg < cmd.nbytes);
    assign cmd_pop  = out_load && cmd_valid && is_last;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = cmd.word[23:16];
            2'd1:    sel_byte = cmd.word[15:8];
            default: sel_byte = cmd.word[7:0];
        endcase
        idx_next = idx_reg;
        if (out_load && cmd_valid)
        begin
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && cmd_valid)
        begin
            data_reg   <= is_data ? sel_byte : 8'd0;
            has_reg    <= is_data;
            fin_reg    <= !is_data;
            status_reg <= is_data ? STATUS_OK : cmd.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= cmd_valid;
            end
            idx_reg <= idx_next;
        end
    end

    assign empty     = !out_valid_reg;
    assign data_byte = data_reg;
    assign has_byte  = has_reg;
    assign is_final  = fin_reg;
    assign status    = status_reg;

    // A waiting result is either a data byte or the end result, and only the latter has status.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((has_byte != is_final) && (has_byte ? status == STATUS_OK : 1'b1)))
        else $error("malformed result");

    // The position inside a command only moves while a command is present.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd_valid) |=> $stable(idx_reg))
        else $error("result index moved without a command");

endmodule
`default_nettype wire

@@ sv/base64_decoder_strict.sv @@
// Top level of the strict base64 decoder: front end, command queue and result sequencer.
// Takes one character per cycle while full is low; a group's results pass through the
// command queue and the output register, and leave it at one per cycle while pop is held,
// so a group of four characters and its up to four results sustain one request per cycle.
// full follows the command queue (CMDQ_DEPTH commands) that parts front and back.
// Asynchronous active-low reset empties the command queue and the output register and starts a fresh string.
`timescale 1ns / 1ps
`default_nettype none
module base64_decoder_strict
#(
    parameter int CMDQ_DEPTH = b64d_pkg::CMDQ_DEPTH_DEFAULT
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] char_code,
    input  wire logic       end_of_text,
    input  wire logic       empty_marker,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      data_byte,
    output logic            has_byte,
    output logic            is_final,
    output logic [1:0]      status
);
    import b64d_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic front_push;
    logic head_valid;
    logic head_pop;

    b64d_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .char_code    (char_code),
        .end_of_text  (end_of_text),
        .empty_marker (empty_marker),
        .cmd_full     (full),
        .cmd          (front_cmd),
        .cmd_push     (front_push)
    );

    b64d_cmdq #(.DEPTH(CMDQ_DEPTH)) u_cmdq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_push),
        .wr_data  (front_cmd),
        .rd_en    (head_pop),
        .rd_data  (head_cmd),
        .rd_valid (head_valid),
        .is_full  (full)
    );

    b64d_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_valid (head_valid),
        .cmd_pop   (head_pop),
        .empty     (empty),
        .pop       (pop),
        .data_byte (data_byte),
        .has_byte  (has_byte),
        .is_final  (is_final),
        .status    (status)
    );

endmodule
`default_nettype wire
